>>> rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the button press classifier
// Register indexes, reset values of the timing registers and the structs
// that carry configuration and events between the core and the top level.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Default timestamp width
  localparam int TIME_BITS_DEF = 48;

  // Widths of the configuration registers
  localparam int CFG_TIME_W  = 24;
  localparam int CFG_COUNT_W = 8;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 3;

  // Width of the repeat counter
  localparam int REP_CNT_W = 8;

  // Register reset values
  localparam logic [CFG_TIME_W-1:0]  DEBOUNCE_RST    = 24'd30000;
  localparam logic [CFG_TIME_W-1:0]  LONG_PRESS_RST  = 24'd500000;
  localparam logic [CFG_TIME_W-1:0]  REPEAT_LEAD_RST = 24'd300000;
  localparam logic [CFG_TIME_W-1:0]  REPEAT_SLOW_RST = 24'd150000;
  localparam logic [CFG_TIME_W-1:0]  REPEAT_FAST_RST = 24'd60000;
  localparam logic [CFG_COUNT_W-1:0] ACCEL_AFTER_RST = 8'd5;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_LONG_PRESS  = 3'd1,
    REG_REPEAT_LEAD = 3'd2,
    REG_REPEAT_SLOW = 3'd3,
    REG_REPEAT_FAST = 3'd4,
    REG_ACCEL_AFTER = 3'd5
  } bpc_reg_idx_t;

  // Current register values
  typedef struct packed {
    logic [CFG_TIME_W-1:0]  debounce_time;
    logic [CFG_TIME_W-1:0]  long_press_time;
    logic [CFG_TIME_W-1:0]  repeat_lead_time;
    logic [CFG_TIME_W-1:0]  repeat_slow_period;
    logic [CFG_TIME_W-1:0]  repeat_fast_period;
    logic [CFG_COUNT_W-1:0] accel_after_count;
  } bpc_cfg_t;

  // Events of one poll
  typedef struct packed {
    logic short_ev;
    logic long_ev;
    logic repeat_ev;
  } bpc_event_t;

endpackage

>>> rtl/core/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier: debounced short, long and auto-repeat presses
// Classifies a stream of button polls into short, long and repeat events.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per poll. tdata from bit 0: time_us (TIME_BITS),
//            pressed_raw, cancel, zero padding to whole bytes.
//   out_*  : exactly one result per poll. tdata from bit 0: short_event,
//            long_event, repeat_event, zero padding.
//   cfg_*  : register writes on any edge with cfg_wr_en high; indexes above five
//            are ignored. The user writes only with no poll in flight; unchecked.
// Throughput: one poll per cycle while out_tready stays high. The poll is
//   captured in an input register, classified in one pass against the state
//   registers and written to the result register, which drives out_tvalid.
// Stall: with out_tready low the result register holds; the input
//   register still takes one more poll, then in_tready drops.
// Reset: all press state clears and the registers return to their
//   default timings at once; no clearing pass.
// ----------------------------------------------------------------------------
module button_press_classifier #(
  parameter int  TIME_BITS = bpc_pkg::TIME_BITS_DEF,
  localparam int IN_DATA_W = ((TIME_BITS + 2 + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // poll requests
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_DATA_W-1:0]          in_tdata,   // time_us, pressed_raw, cancel
  // results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // short, long, repeat event
  // configuration writes
  input  logic                          cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bpc_pkg::*;

  bpc_cfg_t             cfg_r;
  logic                 in_valid_r;
  logic [TIME_BITS-1:0] in_time_r;
  logic                 in_level_r;
  logic                 in_cancel_r;
  logic                 out_valid_r;
  bpc_event_t           out_ev_r;
  bpc_event_t           step_ev;
  logic                 long_done;
  logic                 advance;
  logic                 step_en;

  // Move the pipeline when the result register is free or being taken
  assign advance   = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time      <= DEBOUNCE_RST;
      cfg_r.long_press_time    <= LONG_PRESS_RST;
      cfg_r.repeat_lead_time   <= REPEAT_LEAD_RST;
      cfg_r.repeat_slow_period <= REPEAT_SLOW_RST;
      cfg_r.repeat_fast_period <= REPEAT_FAST_RST;
      cfg_r.accel_after_count  <= ACCEL_AFTER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEBOUNCE:    cfg_r.debounce_time      <= cfg_wdata;
        REG_LONG_PRESS:  cfg_r.long_press_time    <= cfg_wdata;
        REG_REPEAT_LEAD: cfg_r.repeat_lead_time   <= cfg_wdata;
        REG_REPEAT_SLOW: cfg_r.repeat_slow_period <= cfg_wdata;
        REG_REPEAT_FAST: cfg_r.repeat_fast_period <= cfg_wdata;
        REG_ACCEL_AFTER: cfg_r.accel_after_count  <= cfg_wdata[CFG_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Input register: poll fields
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_time_r   <= in_tdata[TIME_BITS-1:0];
      in_level_r  <= in_tdata[TIME_BITS];
      in_cancel_r <= in_tdata[TIME_BITS+1];
    end
  end

  // Classify one poll against the press state
  bpc_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .now       (in_time_r),
    .level     (in_level_r),
    .cancel    (in_cancel_r),
    .cfg       (cfg_r),
    .ev        (step_ev),
    .long_done (long_done)
  );

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  // Result register: events
  always_ff @(posedge clk) begin
    if (step_en) begin
      out_ev_r <= step_ev;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_ev_r.repeat_ev, out_ev_r.long_ev, out_ev_r.short_ev};

  // At most one event per poll
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[2:0]))
    else $error("more than one event in one result");

  // A cancelled poll gives no event
  a_cancel_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && in_cancel_r) |=> (out_tvalid && out_tdata[2:0] == 3'b000))
    else $error("cancelled poll produced an event");

  // A long event leaves the press marked as long
  a_long_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && step_ev.long_ev) |=> long_done)
    else $error("long event without long state");

  // Input stalls only with both registers full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

endmodule

>>> rtl/core/bpc_engine.sv
// ----------------------------------------------------------------------------
// bpc_engine: debounce and press classification state
// Holds the debounce and hold state and, for each poll step, works out the
// next state and the event of that poll in one pass of logic.
// ----------------------------------------------------------------------------
module bpc_engine #(
  parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 level,
  input  logic                 cancel,
  input  bpc_pkg::bpc_cfg_t    cfg,
  output bpc_pkg::bpc_event_t  ev,
  output logic                 long_done
);
  import bpc_pkg::*;

  localparam int EXT_W = TIME_BITS - CFG_TIME_W;

  logic                 level_seen_r, level_seen_nxt;
  logic [TIME_BITS-1:0] level_change_r, level_change_nxt;
  logic                 held_r, held_nxt;
  logic [TIME_BITS-1:0] hold_start_r, hold_start_nxt;
  logic                 long_done_r, long_done_nxt;
  logic [REP_CNT_W-1:0] rep_cnt_r, rep_cnt_nxt;
  logic [TIME_BITS-1:0] next_rep_r, next_rep_nxt;

  logic [TIME_BITS-1:0] change_eff;
  logic [TIME_BITS-1:0] settle_el;
  logic [TIME_BITS-1:0] hold_el;
  logic [TIME_BITS-1:0] rep_delta;
  logic                 settled;
  logic                 long_hit;
  logic                 rep_due;
  logic [REP_CNT_W-1:0] cnt_inc;
  logic [CFG_TIME_W-1:0] period;

  // Elapsed times; level change restarts the settle window now
  assign change_eff = (level != level_seen_r) ? now : level_change_r;
  assign settle_el  = now - change_eff;
  assign hold_el    = now - hold_start_r;
  assign rep_delta  = now - next_rep_r;
  assign settled    = settle_el >= {{EXT_W{1'b0}}, cfg.debounce_time};
  assign long_hit   = hold_el >= {{EXT_W{1'b0}}, cfg.long_press_time};
  // Deadline reached when the wrapped difference is in the lower half
  assign rep_due    = ~rep_delta[TIME_BITS-1];

  // Saturating repeat count and period choice on the updated count
  assign cnt_inc = (rep_cnt_r == {REP_CNT_W{1'b1}}) ? rep_cnt_r
                                                    : rep_cnt_r + 1'b1;
  assign period  = (cnt_inc >= cfg.accel_after_count) ? cfg.repeat_fast_period
                                                      : cfg.repeat_slow_period;

  // Next state and event of this poll
  always_comb begin
    level_seen_nxt   = level_seen_r;
    level_change_nxt = level_change_r;
    held_nxt         = held_r;
    hold_start_nxt   = hold_start_r;
    long_done_nxt    = long_done_r;
    rep_cnt_nxt      = rep_cnt_r;
    next_rep_nxt     = next_rep_r;
    ev               = '0;
    if (cancel) begin
      level_seen_nxt   = 1'b0;
      level_change_nxt = '0;
      held_nxt         = 1'b0;
      hold_start_nxt   = '0;
      long_done_nxt    = 1'b0;
      rep_cnt_nxt      = '0;
      next_rep_nxt     = '0;
    end else begin
      level_seen_nxt   = level;
      level_change_nxt = change_eff;
      if (settled) begin
        if (level && !held_r) begin
          held_nxt       = 1'b1;
          hold_start_nxt = now;
          long_done_nxt  = 1'b0;
          rep_cnt_nxt    = '0;
        end else if (level && !long_done_r && long_hit) begin
          long_done_nxt = 1'b1;
          ev.long_ev    = 1'b1;
          next_rep_nxt  = now + {{EXT_W{1'b0}}, cfg.repeat_lead_time};
        end else if (level && long_done_r && rep_due) begin
          ev.repeat_ev = 1'b1;
          rep_cnt_nxt  = cnt_inc;
          next_rep_nxt = now + {{EXT_W{1'b0}}, period};
        end else if (!level && held_r) begin
          held_nxt    = 1'b0;
          ev.short_ev = !long_done_r;
        end
      end
    end
  end

  // Hold state; advance on each poll step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_seen_r   <= 1'b0;
      level_change_r <= '0;
      held_r         <= 1'b0;
      hold_start_r   <= '0;
      long_done_r    <= 1'b0;
      rep_cnt_r      <= '0;
      next_rep_r     <= '0;
    end else if (step_en) begin
      level_seen_r   <= level_seen_nxt;
      level_change_r <= level_change_nxt;
      held_r         <= held_nxt;
      hold_start_r   <= hold_start_nxt;
      long_done_r    <= long_done_nxt;
      rep_cnt_r      <= rep_cnt_nxt;
      next_rep_r     <= next_rep_nxt;
    end
  end

  assign long_done = long_done_r;

endmodule
